// ===== rtl/dsbr_pkg.sv =====
// shared types and constants for the decimal text to bcd real converter
package dsbr_pkg;

    localparam int EXP_ACC_W = 14;
    localparam logic [EXP_ACC_W-1:0] EXP_SAT = 14'd9999;
    localparam int PP_W  = 8;
    localparam int CNT_W = 7;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int WORD_W  = 64;
    localparam logic [3:0] SIGN_NEG_NIB = 4'd9;
    localparam logic [3:0] SIGN_POS_NIB = 4'd0;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        CLS_WS,
        CLS_DIGIT,
        CLS_RADIX,
        CLS_EXP,
        CLS_PLUS,
        CLS_MINUS,
        CLS_BAD
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       last;
    } t_tok;

    typedef struct packed {
        logic                        vld;
        logic                        syntax_ok;
        logic                        nonzero;
        logic                        sign_neg;
        logic                        exp_neg;
        logic [EXP_ACC_W-1:0]        exp_acc;
        logic signed [PP_W-1:0]      point_pos;
    } t_fin;

endpackage

// ===== rtl/dsbr_if.sv =====
// handshake channels: character input, radix configuration, result output
interface dsbr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dsbr_cfg_if;
    logic valid;
    logic ready;
    logic radix_is_comma;
    modport source (output valid, output radix_is_comma, input ready);
    modport sink   (input valid, input radix_is_comma, output ready);
endinterface

interface dsbr_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [63:0] bcd_word;
    modport source (output valid, output valid_res, output bcd_word, input ready);
    modport sink   (input valid, input valid_res, input bcd_word, output ready);
endinterface

// ===== rtl/dsbr_front.sv =====
// front end: radix register and character classification
module dsbr_front import dsbr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsbr_cfg_if.sink  i_cfg,
    dsbr_char_if.sink i_char,
    input  logic      i_q_full,
    output logic      o_push,
    output t_tok      o_tok
);

    logic       r_radix_comma;
    logic [7:0] radix_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_comma <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_radix_comma <= i_cfg.radix_is_comma;
        end
    end

    assign i_cfg.ready  = 1'b1;
    assign i_char.ready = !i_q_full;
    assign o_push       = i_char.valid && !i_q_full;

    always_comb begin
        radix_ch    = r_radix_comma ? CH_COMMA : CH_DOT;
        o_tok.last  = i_char.last_char;
        o_tok.digit = 4'd0;
        if (i_char.char_code inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
            o_tok.cls = CLS_WS;
        end else if (i_char.char_code inside {[CH_0:CH_9]}) begin
            o_tok.cls   = CLS_DIGIT;
            o_tok.digit = i_char.char_code[3:0];
        end else if (i_char.char_code == radix_ch) begin
            o_tok.cls = CLS_RADIX;
        end else if (i_char.char_code inside {CH_E_UP, CH_E_LO}) begin
            o_tok.cls = CLS_EXP;
        end else if (i_char.char_code == CH_PLUS) begin
            o_tok.cls = CLS_PLUS;
        end else if (i_char.char_code == CH_MINUS) begin
            o_tok.cls = CLS_MINUS;
        end else begin
            o_tok.cls = CLS_BAD;
        end
    end

endmodule

// ===== rtl/dsbr_queue.sv =====
// short token queue between front end and parser
module dsbr_queue import dsbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_tok o_tok
);

    t_tok            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/dsbr_parse.sv =====
// back end: grammar state machine, mantissa digit store and exponent accumulation
module dsbr_parse import dsbr_pkg::*; #(
    parameter int MANT_DIGITS = 12,
    parameter int MAX_CHARS   = 80
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tok                     i_tok,
    input  logic                     i_avail,
    input  logic                     i_en,
    output logic                     o_pop,
    output t_fin                     o_fin,
    output logic [MANT_DIGITS*4-1:0] o_mant
);

    localparam int IW = (MANT_DIGITS > 1) ? $clog2(MANT_DIGITS) : 1;
    localparam int CW = $clog2(MANT_DIGITS + 1);

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_SIGNED,
        PH_INT,
        PH_FRAC0,
        PH_FRAC,
        PH_EXPS,
        PH_EXP1,
        PH_EXPD,
        PH_ZTAIL,
        PH_TRAIL
    } t_phase;

    t_phase                 r_phase, n_phase, ph_eff;
    logic                   r_sign_neg, n_sign_neg;
    logic [3:0]             r_mant [MANT_DIGITS];
    logic [3:0]             n_mant [MANT_DIGITS];
    logic [CW-1:0]          r_ndig, n_ndig;
    logic signed [PP_W-1:0] r_pp, n_pp;
    logic                   r_nz, n_nz;
    logic [EXP_ACC_W-1:0]   r_acc, n_acc, acc_sat;
    logic [EXP_ACC_W+2:0]   acc_x10;
    logic                   r_eneg, n_eneg;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_failed, n_failed;
    t_fin                   r_fin;
    logic [MANT_DIGITS*4-1:0] r_mant_out, mant_flat;
    logic                   int_step, frac_step, exp_step, keep, nz_digit;
    logic                   is_ws, is_dig, is_rad, is_exp, is_sign, is_minus;
    logic                   syntax_ok, finish;

    function automatic logic end_ok(input t_phase ph);
        return (ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXPD) || (ph == PH_ZTAIL);
    endfunction

    assign o_pop  = i_avail && i_en;
    assign finish = o_pop && i_tok.last;
    assign o_fin  = r_fin;
    assign o_mant = r_mant_out;

    always_comb begin
        n_phase    = r_phase;
        n_sign_neg = r_sign_neg;
        n_mant     = r_mant;
        n_ndig     = r_ndig;
        n_pp       = r_pp;
        n_nz       = r_nz;
        n_acc      = r_acc;
        n_eneg     = r_eneg;
        n_cnt      = r_cnt;
        n_failed   = r_failed;
        int_step   = 1'b0;
        frac_step  = 1'b0;
        exp_step   = 1'b0;
        keep       = 1'b0;
        is_ws      = (i_tok.cls == CLS_WS);
        is_dig     = (i_tok.cls == CLS_DIGIT);
        is_rad     = (i_tok.cls == CLS_RADIX);
        is_exp     = (i_tok.cls == CLS_EXP);
        is_minus   = (i_tok.cls == CLS_MINUS);
        is_sign    = is_minus || (i_tok.cls == CLS_PLUS);
        nz_digit   = r_nz || (i_tok.digit != 4'd0);
        ph_eff     = (r_phase == PH_LEAD) ? PH_SIGNED : r_phase;

        // exponent digits saturate well above any legal exponent
        acc_x10 = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {13'd0, i_tok.digit};
        acc_sat = (acc_x10 > (EXP_ACC_W+3)'(EXP_SAT)) ? EXP_SAT : acc_x10[EXP_ACC_W-1:0];

        if (!r_failed) begin
            if (r_phase == PH_TRAIL) begin
                if (!is_ws) begin
                    n_failed = 1'b1;
                end
            end else if (is_ws) begin
                if (r_phase != PH_LEAD) begin
                    if (end_ok(r_phase)) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
            end else if (r_cnt >= CNT_W'(MAX_CHARS - 1)) begin
                n_failed = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
                if (i_tok.cls == CLS_BAD) begin
                    n_failed = 1'b1;
                end else if (r_phase == PH_LEAD && is_sign) begin
                    n_phase    = PH_SIGNED;
                    n_sign_neg = is_minus;
                end else begin
                    n_phase = ph_eff;
                    case (ph_eff)
                        PH_SIGNED: begin
                            if (is_dig) begin
                                int_step = 1'b1;
                                n_phase  = PH_INT;
                            end else if (is_rad) begin
                                n_phase = PH_FRAC0;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        PH_INT: begin
                            if (is_dig) begin
                                int_step = 1'b1;
                            end else if (is_rad) begin
                                n_phase = PH_FRAC;
                            end else if (is_exp) begin
                                n_phase = r_nz ? PH_EXPS : PH_ZTAIL;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        PH_FRAC0: begin
                            if (is_dig) begin
                                frac_step = 1'b1;
                                n_phase   = PH_FRAC;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        PH_FRAC: begin
                            if (is_dig) begin
                                frac_step = 1'b1;
                            end else if (!r_nz) begin
                                n_phase = PH_ZTAIL;
                            end else if (is_exp) begin
                                n_phase = PH_EXPS;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        PH_EXPS: begin
                            if (is_sign) begin
                                n_eneg  = is_minus;
                                n_phase = PH_EXP1;
                            end else if (is_dig) begin
                                exp_step = 1'b1;
                                n_phase  = PH_EXPD;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        PH_EXP1, PH_EXPD: begin
                            if (is_dig) begin
                                exp_step = 1'b1;
                                n_phase  = PH_EXPD;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        // leading zeros take no digit slot; those after the radix move the point instead
        if (int_step && nz_digit) begin
            n_nz = 1'b1;
            n_pp = r_pp + 8'sd1;
            keep = 1'b1;
        end
        if (frac_step) begin
            if (nz_digit) begin
                n_nz = 1'b1;
                keep = 1'b1;
            end else begin
                n_pp = r_pp - 8'sd1;
            end
        end
        if (keep && (r_ndig < CW'(MANT_DIGITS))) begin
            n_mant[r_ndig[IW-1:0]] = i_tok.digit;
            n_ndig                 = r_ndig + 1'b1;
        end
        if (exp_step) begin
            n_acc = acc_sat;
        end

        // first stored digit goes to the most significant nibble
        for (int i = 0; i < MANT_DIGITS; i++) begin
            mant_flat[4*(MANT_DIGITS-1-i) +: 4] = n_mant[i];
        end
        syntax_ok = !n_failed && ((n_phase == PH_TRAIL) || end_ok(n_phase));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEAD;
            r_sign_neg <= 1'b0;
            r_ndig     <= '0;
            r_pp       <= '0;
            r_nz       <= 1'b0;
            r_acc      <= '0;
            r_eneg     <= 1'b0;
            r_cnt      <= '0;
            r_failed   <= 1'b0;
            r_fin.vld  <= 1'b0;
            for (int i = 0; i < MANT_DIGITS; i++) begin
                r_mant[i] <= 4'd0;
            end
        end else begin
            if (i_en) begin
                r_fin.vld <= finish;
            end
            if (finish) begin
                r_fin.syntax_ok <= syntax_ok;
                r_fin.nonzero   <= n_nz;
                r_fin.sign_neg  <= n_sign_neg;
                r_fin.exp_neg   <= n_eneg;
                r_fin.exp_acc   <= n_acc;
                r_fin.point_pos <= n_pp;
                r_mant_out      <= mant_flat;
                r_phase         <= PH_LEAD;
                r_sign_neg      <= 1'b0;
                r_ndig          <= '0;
                r_pp            <= '0;
                r_nz            <= 1'b0;
                r_acc           <= '0;
                r_eneg          <= 1'b0;
                r_cnt           <= '0;
                r_failed        <= 1'b0;
                for (int i = 0; i < MANT_DIGITS; i++) begin
                    r_mant[i] <= 4'd0;
                end
            end else if (o_pop) begin
                r_phase    <= n_phase;
                r_sign_neg <= n_sign_neg;
                r_mant     <= n_mant;
                r_ndig     <= n_ndig;
                r_pp       <= n_pp;
                r_nz       <= n_nz;
                r_acc      <= n_acc;
                r_eneg     <= n_eneg;
                r_cnt      <= n_cnt;
                r_failed   <= n_failed;
            end
        end
    end

endmodule

// ===== rtl/dsbr_fmt.sv =====
// result pipeline: exponent range check, binary to bcd per stage, output register
module dsbr_fmt import dsbr_pkg::*; #(
    parameter int MANT_DIGITS = 12,
    parameter int EXP_DIGITS  = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_fin                     i_fin,
    input  logic [MANT_DIGITS*4-1:0] i_mant,
    output logic                     o_en,
    dsbr_res_if.source               o_res
);

    localparam int ED = EXP_DIGITS;
    localparam int MW = MANT_DIGITS * 4;
    localparam int EW = EXP_DIGITS * 4;
    localparam int FW = EW + MW + 4;
    localparam int MAXE = 5 * (10 ** (EXP_DIGITS - 1));
    localparam logic signed [15:0] MAXE_S     = 16'(MAXE);
    localparam logic signed [15:0] TWO_MAXE_S = 16'(2 * MAXE);
    // v / 10 == (v * 52429) >> 19 for every v below 43690
    localparam logic [29:0] RECIP10 = 30'd52429;
    localparam int RSH = 19;

    logic                 r_vld  [0:ED];
    logic                 r_ok   [0:ED];
    logic                 r_nz   [0:ED];
    logic                 r_sgn  [0:ED];
    logic [MW-1:0]        r_mant [0:ED];
    logic [EXP_ACC_W-1:0] r_v    [0:ED];
    logic [EW-1:0]        r_exp  [0:ED];

    logic [29:0]          prod   [1:ED];
    logic [EXP_ACC_W-1:0] quot   [1:ED];
    logic [EXP_ACC_W-1:0] rem    [1:ED];
    logic [EW-1:0]        n_exp  [1:ED];

    logic signed [15:0]   acc_s, pp_s, e_raw, e_adj;
    logic                 in_range, ok0;
    logic [FW-1:0]        word_full;

    assign o_en = !(r_vld[ED] && !o_res.ready);

    always_comb begin
        acc_s    = {2'b00, i_fin.exp_acc};
        pp_s     = {{(16-PP_W){i_fin.point_pos[PP_W-1]}}, i_fin.point_pos};
        e_raw    = (i_fin.exp_neg ? -acc_s : acc_s) + pp_s - 16'sd1;
        in_range = (e_raw > -MAXE_S) && (e_raw < MAXE_S);
        e_adj    = (e_raw < 16'sd0) ? (e_raw + TWO_MAXE_S) : e_raw;
        ok0      = i_fin.syntax_ok && (!i_fin.nonzero || in_range);
    end

    always_comb begin
        for (int k = 1; k <= ED; k++) begin
            prod[k]  = 30'(r_v[k-1]) * RECIP10;
            quot[k]  = EXP_ACC_W'(prod[k] >> RSH);
            rem[k]   = r_v[k-1] - ({quot[k][EXP_ACC_W-4:0], 3'b000} + {quot[k][EXP_ACC_W-2:0], 1'b0});
            n_exp[k] = r_exp[k-1];
            n_exp[k][4*(k-1) +: 4] = rem[k][3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ED; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (o_en) begin
            r_vld[0] <= i_fin.vld;
            for (int k = 1; k <= ED; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_ok[0]   <= ok0;
            r_nz[0]   <= i_fin.nonzero;
            r_sgn[0]  <= i_fin.sign_neg;
            r_mant[0] <= i_mant;
            r_v[0]    <= e_adj[EXP_ACC_W-1:0];
            r_exp[0]  <= '0;
            for (int k = 1; k <= ED; k++) begin
                r_ok[k]   <= r_ok[k-1];
                r_nz[k]   <= r_nz[k-1];
                r_sgn[k]  <= r_sgn[k-1];
                r_mant[k] <= r_mant[k-1];
                r_v[k]    <= quot[k];
                r_exp[k]  <= n_exp[k];
            end
        end
    end

    // nibbles beyond the word width fall off in the size cast
    assign word_full = {(r_sgn[ED] ? SIGN_NEG_NIB : SIGN_POS_NIB), r_mant[ED], r_exp[ED]};

    assign o_res.valid     = r_vld[ED];
    assign o_res.valid_res = r_ok[ED];
    assign o_res.bcd_word  = (r_ok[ED] && r_nz[ED]) ? WORD_W'(word_full) : '0;

endmodule

// ===== rtl/decimal_string_to_bcd_real.sv =====
// decimal text to bcd real converter: characters in, one packed word out per string
// result path: parser finish record, range-check stage, then the bcd exponent stages
// throughput: one character per cycle unless the output stalls; parser steps on the queue head
// the exponent pipeline has one bcd digit stage per exponent digit; a four-entry queue parts
// front end and parser; sync active-low reset clears parser, queue, pipeline and radix to '.'
module decimal_string_to_bcd_real import dsbr_pkg::*; #(
    parameter int MANT_DIGITS = 12,
    parameter int EXP_DIGITS  = 3,
    parameter int MAX_CHARS   = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsbr_cfg_if.sink    i_cfg,
    dsbr_char_if.sink   i_char,
    dsbr_res_if.source  o_res
);

    logic                     q_full;
    logic                     q_empty;
    logic                     push;
    logic                     pop;
    logic                     en;
    t_tok                     tok_in;
    t_tok                     tok_out;
    t_fin                     fin;
    logic [MANT_DIGITS*4-1:0] mant;

    dsbr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_char   (i_char),
        .i_q_full (q_full),
        .o_push   (push),
        .o_tok    (tok_in)
    );

    dsbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (tok_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_tok   (tok_out)
    );

    dsbr_parse #(
        .MANT_DIGITS (MANT_DIGITS),
        .MAX_CHARS   (MAX_CHARS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_out),
        .i_avail (!q_empty),
        .i_en    (en),
        .o_pop   (pop),
        .o_fin   (fin),
        .o_mant  (mant)
    );

    dsbr_fmt #(
        .MANT_DIGITS (MANT_DIGITS),
        .EXP_DIGITS  (EXP_DIGITS)
    ) u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fin   (fin),
        .i_mant  (mant),
        .o_en    (en),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/dsbr_checker.sv =====
// port-level checks on the converter and their binding to the top level
module dsbr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        i_cfg_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_valid_res,
    input logic [63:0] i_res_word
);

    // a stalled transaction keeps its payload
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_word) && $stable(i_res_valid_res))
        else $error("result changed while stalled");

    // a rejected string carries an all-zero word
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_valid_res |-> i_res_word == 64'd0)
        else $error("rejected result with nonzero word");

    // on an accepted result the lowest exponent nibble is a decimal digit
    a_exp_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_valid_res |-> i_res_word[3:0] <= 4'd9)
        else $error("exponent nibble is not bcd");

    // radix writes are never held off
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> i_cfg_ready)
        else $error("configuration write stalled");

    // reset empties the result pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid straight after reset");

endmodule

bind decimal_string_to_bcd_real dsbr_checker u_dsbr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_valid     (i_cfg.valid),
    .i_cfg_ready     (i_cfg.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_valid_res (o_res.valid_res),
    .i_res_word      (o_res.bcd_word)
);
